// ----- hw/rtl/digp_pkg.sv -----
// Package for the delimited integer grid parser: item types, parse phases,
// result and error codes, character constants. No dependencies.
package digp_pkg;

    localparam int CELL_BITS   = 16;
    localparam int LINE_BITS   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [0:0] REG_SEPARATOR = 1'b0;
    localparam logic [7:0] SEP_RESET     = 8'd32;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [2:0] KIND_WIDTH  = 3'd0;
    localparam logic [2:0] KIND_HEIGHT = 3'd1;
    localparam logic [2:0] KIND_CELL   = 3'd2;
    localparam logic [2:0] KIND_ROWEND = 3'd3;
    localparam logic [2:0] KIND_OK     = 3'd4;
    localparam logic [2:0] KIND_ERR    = 3'd5;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NO_WIDTH     = 3'd0;
    localparam logic [2:0] ERR_NO_WIDTH_NL  = 3'd1;
    localparam logic [2:0] ERR_NO_HEIGHT    = 3'd2;
    localparam logic [2:0] ERR_NO_HEIGHT_NL = 3'd3;
    localparam logic [2:0] ERR_BAD_ROW      = 3'd4;

    typedef enum logic [3:0] {
        PH_WNUM,
        PH_WNL,
        PH_HNUM,
        PH_ROWNL,
        PH_RNUM,
        PH_RBLANK,
        PH_RSEP
    } digp_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } digp_item_t;

    typedef struct packed {
        logic [2:0]           result_kind;
        logic [31:0]          number_value;
        logic [2:0]           error_code;
        logic [LINE_BITS-1:0] line_number;
        logic                 last_of_run;
    } digp_result_t;

    typedef struct packed {
        logic [1:0]   count;
        digp_result_t first;
        digp_result_t second;
    } digp_push_t;

endpackage

// ----- hw/rtl/digp_regs.sv -----
// Configuration register file of the grid parser, APB-style write/read port.
// Depends on digp_pkg.
module digp_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [digp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [digp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [digp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [7:0]                        separator
);

    logic       wr_en;
    logic [0:0] reg_index;
    logic [7:0] separator_reg;

    assign reg_index = paddr[2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign separator = separator_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= digp_pkg::SEP_RESET;
        end
        else if (wr_en && reg_index == digp_pkg::REG_SEPARATOR)
        begin
            separator_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == digp_pkg::REG_SEPARATOR)
        begin
            prdata = digp_pkg::APB_DATA_W'(separator_reg);
        end
    end

endmodule

// ----- hw/rtl/digp_core.sv -----
// Parse state and per-character step logic of the grid parser; produces up
// to two result items per accepted item. Depends on digp_pkg.
module digp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  digp_pkg::digp_item_t item,
    input  logic [7:0]           separator,
    output digp_pkg::digp_push_t push
);

    localparam logic [digp_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [digp_pkg::LINE_BITS-1:0] LINE_ONE = digp_pkg::LINE_BITS'(1);

    digp_pkg::digp_phase_t             phase_reg, phase_next;
    logic [31:0]                       acc_reg, acc_next;
    logic                              minus_reg, minus_next;
    logic                              digits_reg, digits_next;
    logic [digp_pkg::LINE_BITS-1:0]    line_reg, line_next;
    logic                              finished_reg, finished_next;

    logic [7:0]  c;
    logic        is_digit, is_minus, is_nl, is_blank, is_sep, blank_mode;
    logic [3:0]  digit_val;
    logic [31:0] acc_times10;
    logic [31:0] num_val;
    logic [31:0] cell_val;
    logic [digp_pkg::LINE_BITS-1:0] line_inc;
    logic        fn_take;

    logic        rep_en;
    logic [2:0]  rep_kind;
    logic [31:0] rep_val;
    logic        tail_en;
    logic [2:0]  tail_kind;
    logic [2:0]  tail_err;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        do_fresh;
    logic [2:0]  fresh_code;
    logic        ac_en;
    logic        ac_blanks;

    digp_pkg::digp_result_t rep_res, tail_res;

    assign c          = item.text_byte;
    assign is_digit   = c inside {[digp_pkg::CH_0:digp_pkg::CH_9]};
    assign is_minus   = (c == digp_pkg::CH_MINUS);
    assign is_nl      = c inside {digp_pkg::CH_LF, digp_pkg::CH_CR};
    assign is_blank   = c inside {digp_pkg::CH_SP, digp_pkg::CH_TAB};
    assign is_sep     = (c == separator);
    assign blank_mode = separator inside {digp_pkg::CH_SP, digp_pkg::CH_TAB};
    assign digit_val  = c[3:0];

    assign acc_times10 = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                       + 32'(digit_val);
    assign num_val  = minus_reg ? (32'd0 - acc_reg) : acc_reg;
    assign cell_val = 32'(num_val[digp_pkg::CELL_BITS-1:0]);
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
    assign fn_take  = is_digit | (!minus_reg & !digits_reg & is_minus);

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        minus_next    = minus_reg;
        digits_next   = digits_reg;
        line_next     = line_reg;
        finished_next = finished_reg;
        rep_en        = 1'b0;
        rep_kind      = digp_pkg::KIND_CELL;
        rep_val       = cell_val;
        tail_en       = 1'b0;
        tail_kind     = digp_pkg::KIND_OK;
        tail_err      = digp_pkg::ERR_NONE;
        fail_en       = 1'b0;
        fail_code     = digp_pkg::ERR_BAD_ROW;
        do_fresh      = 1'b0;
        fresh_code    = digp_pkg::ERR_BAD_ROW;
        ac_en         = 1'b0;
        ac_blanks     = 1'b0;

        if (item.end_of_text)
        begin
            if (!finished_reg)
            begin
                tail_en = 1'b1;
                case (phase_reg)
                    digp_pkg::PH_WNUM:
                    begin
                        tail_kind = digp_pkg::KIND_ERR;
                        if (digits_reg)
                        begin
                            rep_en   = 1'b1;
                            rep_kind = digp_pkg::KIND_WIDTH;
                            rep_val  = num_val;
                            tail_err = digp_pkg::ERR_NO_WIDTH_NL;
                        end
                        else
                        begin
                            tail_err = digp_pkg::ERR_NO_WIDTH;
                        end
                    end
                    digp_pkg::PH_WNL:
                    begin
                        tail_kind = digp_pkg::KIND_ERR;
                        tail_err  = digp_pkg::ERR_NO_HEIGHT;
                    end
                    digp_pkg::PH_HNUM:
                    begin
                        tail_kind = digp_pkg::KIND_ERR;
                        if (digits_reg)
                        begin
                            rep_en   = 1'b1;
                            rep_kind = digp_pkg::KIND_HEIGHT;
                            rep_val  = num_val;
                            tail_err = digp_pkg::ERR_NO_HEIGHT_NL;
                        end
                        else
                        begin
                            tail_err = digp_pkg::ERR_NO_HEIGHT;
                        end
                    end
                    digp_pkg::PH_RNUM:
                    begin
                        rep_en = digits_reg;
                    end
                    default:
                    begin
                        tail_kind = digp_pkg::KIND_OK;
                    end
                endcase
            end
            phase_next    = digp_pkg::PH_WNUM;
            acc_next      = '0;
            minus_next    = 1'b0;
            digits_next   = 1'b0;
            line_next     = LINE_ONE;
            finished_next = 1'b0;
        end
        else if (!finished_reg)
        begin
            case (phase_reg)
                digp_pkg::PH_WNUM, digp_pkg::PH_HNUM:
                begin
                    if (fn_take)
                    begin
                        if (is_digit)
                        begin
                            acc_next    = acc_times10;
                            digits_next = 1'b1;
                        end
                        else
                        begin
                            minus_next = 1'b1;
                        end
                    end
                    else if (!digits_reg)
                    begin
                        fail_en   = 1'b1;
                        fail_code = (phase_reg == digp_pkg::PH_WNUM) ?
                                    digp_pkg::ERR_NO_WIDTH : digp_pkg::ERR_NO_HEIGHT;
                    end
                    else
                    begin
                        rep_en   = 1'b1;
                        rep_kind = (phase_reg == digp_pkg::PH_WNUM) ?
                                   digp_pkg::KIND_WIDTH : digp_pkg::KIND_HEIGHT;
                        rep_val  = num_val;
                        if (is_nl)
                        begin
                            line_next  = line_inc;
                            phase_next = (phase_reg == digp_pkg::PH_WNUM) ?
                                         digp_pkg::PH_WNL : digp_pkg::PH_ROWNL;
                        end
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = (phase_reg == digp_pkg::PH_WNUM) ?
                                        digp_pkg::ERR_NO_WIDTH_NL :
                                        digp_pkg::ERR_NO_HEIGHT_NL;
                        end
                    end
                end
                digp_pkg::PH_WNL, digp_pkg::PH_ROWNL:
                begin
                    if (!is_nl)
                    begin
                        do_fresh = 1'b1;
                        if (phase_reg == digp_pkg::PH_WNL)
                        begin
                            phase_next = digp_pkg::PH_HNUM;
                            fresh_code = digp_pkg::ERR_NO_HEIGHT;
                        end
                        else
                        begin
                            phase_next = digp_pkg::PH_RNUM;
                        end
                    end
                end
                digp_pkg::PH_RNUM:
                begin
                    if (fn_take)
                    begin
                        if (is_digit)
                        begin
                            acc_next    = acc_times10;
                            digits_next = 1'b1;
                        end
                        else
                        begin
                            minus_next = 1'b1;
                        end
                    end
                    else if (!digits_reg)
                    begin
                        fail_en = 1'b1;
                    end
                    else
                    begin
                        rep_en = 1'b1;
                        ac_en  = 1'b1;
                    end
                end
                digp_pkg::PH_RBLANK:
                begin
                    ac_en     = 1'b1;
                    ac_blanks = 1'b1;
                end
                digp_pkg::PH_RSEP:
                begin
                    if (!is_blank)
                    begin
                        phase_next = digp_pkg::PH_RNUM;
                        do_fresh   = 1'b1;
                    end
                end
                default:
                begin
                    fail_en = 1'b1;
                end
            endcase

            // byte after a finished cell
            if (ac_en)
            begin
                if (is_blank)
                begin
                    phase_next = digp_pkg::PH_RBLANK;
                end
                else if (!blank_mode && is_sep)
                begin
                    phase_next = digp_pkg::PH_RSEP;
                end
                else if (is_nl)
                begin
                    tail_en    = 1'b1;
                    tail_kind  = digp_pkg::KIND_ROWEND;
                    line_next  = line_inc;
                    phase_next = digp_pkg::PH_ROWNL;
                end
                else if (blank_mode && ac_blanks && (is_minus || is_digit))
                begin
                    phase_next = digp_pkg::PH_RNUM;
                    do_fresh   = 1'b1;
                end
                else
                begin
                    fail_en = 1'b1;
                end
            end

            // start a new number with this byte
            if (do_fresh)
            begin
                acc_next    = is_digit ? 32'(digit_val) : 32'd0;
                digits_next = is_digit;
                minus_next  = is_minus;
                if (!(is_digit || is_minus))
                begin
                    fail_en   = 1'b1;
                    fail_code = fresh_code;
                end
            end

            if (fail_en)
            begin
                tail_en       = 1'b1;
                tail_kind     = digp_pkg::KIND_ERR;
                tail_err      = fail_code;
                finished_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        rep_res.result_kind   = rep_kind;
        rep_res.number_value  = rep_val;
        rep_res.error_code    = digp_pkg::ERR_NONE;
        rep_res.line_number   = line_reg;
        rep_res.last_of_run   = !tail_en;
        tail_res.result_kind  = tail_kind;
        tail_res.number_value = '0;
        tail_res.error_code   = tail_err;
        tail_res.line_number  = line_reg;
        tail_res.last_of_run  = 1'b1;

        push.count  = 2'(rep_en) + 2'(tail_en);
        push.first  = rep_en ? rep_res : tail_res;
        push.second = tail_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= digp_pkg::PH_WNUM;
            acc_reg      <= '0;
            minus_reg    <= 1'b0;
            digits_reg   <= 1'b0;
            line_reg     <= LINE_ONE;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            minus_reg    <= minus_next;
            digits_reg   <= digits_next;
            line_reg     <= line_next;
            finished_reg <= finished_next;
        end
    end

`ifndef SYNTH
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && finished_reg && !item.end_of_text) |-> (push.count == 2'd0))
        else $error("result produced after parse error");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter reached zero");

    a_restart_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_text) |=>
            (phase_reg == digp_pkg::PH_WNUM && line_reg == LINE_ONE && !finished_reg))
        else $error("parser not restarted after end of text");
`endif

endmodule

// ----- hw/rtl/digp_queue.sv -----
// Result queue of the grid parser: takes up to two result items per cycle,
// hands out one. Depends on digp_pkg.
module digp_queue
#(
    parameter int DEPTH = digp_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  digp_pkg::digp_push_t   push,
    output logic                   space_ok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output digp_pkg::digp_result_t out_item
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    digp_pkg::digp_result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] tail_plus1;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_n;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
        return nxt;
    endfunction

    assign push_n     = push_en ? push.count : 2'd0;
    assign pop        = out_valid & out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_item   = entry_reg[head_reg];
    assign space_ok   = (count_reg <= CNT_W'(DEPTH - 2));
    assign tail_plus1 = wrap_inc(tail_reg);

    always_comb
    begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
        case (push_n)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = wrap_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg <= CNT_W'(DEPTH - 2)))
        else $error("push into queue without room for two items");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0 && !pop) |=>
            (count_reg == $past(count_reg) + CNT_W'($past(push_n))))
        else $error("queue count does not follow pushes");
`endif

endmodule

// ----- hw/rtl/delimited_integer_grid_parser_unit.sv -----
// Top level of the delimited integer grid parser: APB register, parse core,
// result queue. Depends on digp_pkg, digp_regs, digp_core, digp_queue.
//
//   channel  | handshake                       | payload
//   item     | item_valid / item_ready         | item (text_byte, end_of_text)
//   result   | result_valid / result_ready     | result (kind, value, error, line, last)
//   config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One character per cycle while item_ready is high: the step logic updates the parse
// state in the cycle an item is accepted and pushes its zero, one or two result items
// into a queue. Results leave one per cycle while result_ready is high; item_ready
// drops while the queue lacks room for two.
// Reset clears the parse state, the queue and sets the separator to a space.
module delimited_integer_grid_parser_unit
#(
    parameter int QUEUE_DEPTH = digp_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  digp_pkg::digp_item_t              item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output digp_pkg::digp_result_t            result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [digp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [digp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [digp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                 accept;
    logic                 space_ok;
    logic [7:0]           separator;
    digp_pkg::digp_push_t push;

    assign item_ready = space_ok;
    assign accept     = item_valid & item_ready;

    digp_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .separator (separator)
    );

    digp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .separator (separator),
        .push      (push)
    );

    digp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result)
    );

endmodule

// ----- dv/delimited_integer_grid_parser_unit_test.sv -----
// Testbench for delimited_integer_grid_parser_unit: drives grid texts under several
// separators and idle mixes, tracks the parse in its own model, and checks each result.
// Depends on digp_pkg and the unit's RTL.
module delimited_integer_grid_parser_unit_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam logic [digp_pkg::APB_ADDR_W-1:0] SEP_ADDR =
        digp_pkg::APB_ADDR_W'(4 * digp_pkg::REG_SEPARATOR);

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            item_valid   = 1'b0;
    logic                            item_ready;
    digp_pkg::digp_item_t            item         = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    digp_pkg::digp_result_t          result;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [digp_pkg::APB_ADDR_W-1:0] paddr        = '0;
    logic [digp_pkg::APB_DATA_W-1:0] pwdata       = '0;
    logic [digp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    delimited_integer_grid_parser_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // parser state mirror
    logic [7:0]                     sep_char;
    digp_pkg::digp_phase_t          parse_state;
    logic [31:0]                    accum;
    logic                           neg_seen;
    logic                           digit_seen;
    logic                           text_done;
    logic [digp_pkg::LINE_BITS-1:0] line_cnt;

    digp_pkg::digp_result_t results_due[$];
    digp_pkg::digp_result_t step_results[$];
    digp_pkg::digp_result_t due_head;
    logic [7:0]             text_buf[$];

    int bad_results    = 0;
    int results_seen   = 0;
    int texts_sent     = 0;
    int chars_sent     = 0;
    int active_items   = 0;
    int settings_used  = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    function automatic bit is_newline(logic [7:0] c);
        return c == digp_pkg::CH_LF || c == digp_pkg::CH_CR;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == digp_pkg::CH_SP || c == digp_pkg::CH_TAB;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= digp_pkg::CH_0 && c <= digp_pkg::CH_9;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [31:0] value,
                                        logic [2:0] code);
        digp_pkg::digp_result_t r;
        r.result_kind  = kind;
        r.number_value = value;
        r.error_code   = code;
        r.line_number  = line_cnt;
        r.last_of_run  = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void raise_error(logic [2:0] code);
        push_result(digp_pkg::KIND_ERR, '0, code);
        text_done = 1'b1;
    endfunction

    function automatic void bump_line();
        if (line_cnt != '1)
            line_cnt = line_cnt + 1'b1;
    endfunction

    function automatic void clear_value();
        accum      = '0;
        neg_seen   = 1'b0;
        digit_seen = 1'b0;
    endfunction

    function automatic void restart_text();
        parse_state = digp_pkg::PH_WNUM;
        clear_value();
        line_cnt    = digp_pkg::LINE_BITS'(1);
        text_done   = 1'b0;
    endfunction

    // 1: taken into the number, 0: number ended before c, -1: no number here
    function automatic int take_digit(logic [7:0] c);
        if (is_digit(c))
        begin
            accum      = accum * 32'd10 + 32'(c - digp_pkg::CH_0);
            digit_seen = 1'b1;
            return 1;
        end
        if (!neg_seen && !digit_seen && c == digp_pkg::CH_MINUS)
        begin
            neg_seen = 1'b1;
            return 1;
        end
        return digit_seen ? 0 : -1;
    endfunction

    function automatic logic [31:0] signed_value();
        return neg_seen ? 32'd0 - accum : accum;
    endfunction

    function automatic logic [31:0] cell_value();
        logic [31:0] mask;
        mask = (digp_pkg::CELL_BITS >= 32) ? '1 :
               ((32'd1 << digp_pkg::CELL_BITS) - 32'd1);
        return signed_value() & mask;
    endfunction

    function automatic void after_cell(logic [7:0] c, bit blanks, output bit again);
        bit blank_sep;
        blank_sep = is_blank(sep_char);
        again     = 1'b0;
        if (is_blank(c))
            parse_state = digp_pkg::PH_RBLANK;
        else if (!blank_sep && c == sep_char)
            parse_state = digp_pkg::PH_RSEP;
        else if (is_newline(c))
        begin
            push_result(digp_pkg::KIND_ROWEND, '0, digp_pkg::ERR_NONE);
            bump_line();
            parse_state = digp_pkg::PH_ROWNL;
        end
        else if (blank_sep && blanks && (c == digp_pkg::CH_MINUS || is_digit(c)))
        begin
            parse_state = digp_pkg::PH_RNUM;
            clear_value();
            again = 1'b1;
        end
        else
            raise_error(digp_pkg::ERR_BAD_ROW);
    endfunction

    function automatic void parse_char(logic [7:0] c);
        bit again;
        bit w;
        int r;
        again = 1'b1;
        while (again && !text_done)
        begin
            again = 1'b0;
            case (parse_state)
                digp_pkg::PH_WNUM, digp_pkg::PH_HNUM:
                begin
                    w = (parse_state == digp_pkg::PH_WNUM);
                    r = take_digit(c);
                    if (r < 0)
                        raise_error(w ? digp_pkg::ERR_NO_WIDTH : digp_pkg::ERR_NO_HEIGHT);
                    else if (r == 0)
                    begin
                        push_result(w ? digp_pkg::KIND_WIDTH : digp_pkg::KIND_HEIGHT,
                                    signed_value(), digp_pkg::ERR_NONE);
                        if (is_newline(c))
                        begin
                            bump_line();
                            parse_state = w ? digp_pkg::PH_WNL : digp_pkg::PH_ROWNL;
                        end
                        else
                            raise_error(w ? digp_pkg::ERR_NO_WIDTH_NL :
                                            digp_pkg::ERR_NO_HEIGHT_NL);
                    end
                end
                digp_pkg::PH_WNL, digp_pkg::PH_ROWNL:
                begin
                    if (!is_newline(c))
                    begin
                        parse_state = (parse_state == digp_pkg::PH_WNL) ?
                                      digp_pkg::PH_HNUM : digp_pkg::PH_RNUM;
                        clear_value();
                        again = 1'b1;
                    end
                end
                digp_pkg::PH_RNUM:
                begin
                    r = take_digit(c);
                    if (r < 0)
                        raise_error(digp_pkg::ERR_BAD_ROW);
                    else if (r == 0)
                    begin
                        push_result(digp_pkg::KIND_CELL, cell_value(), digp_pkg::ERR_NONE);
                        after_cell(c, 1'b0, again);
                    end
                end
                digp_pkg::PH_RBLANK:
                    after_cell(c, 1'b1, again);
                digp_pkg::PH_RSEP:
                begin
                    if (!is_blank(c))
                    begin
                        parse_state = digp_pkg::PH_RNUM;
                        clear_value();
                        again = 1'b1;
                    end
                end
                default:
                    raise_error(digp_pkg::ERR_BAD_ROW);
            endcase
        end
    endfunction

    function automatic void close_text();
        case (parse_state)
            digp_pkg::PH_WNUM:
            begin
                if (digit_seen)
                begin
                    push_result(digp_pkg::KIND_WIDTH, signed_value(), digp_pkg::ERR_NONE);
                    raise_error(digp_pkg::ERR_NO_WIDTH_NL);
                end
                else
                    raise_error(digp_pkg::ERR_NO_WIDTH);
            end
            digp_pkg::PH_WNL:
                raise_error(digp_pkg::ERR_NO_HEIGHT);
            digp_pkg::PH_HNUM:
            begin
                if (digit_seen)
                begin
                    push_result(digp_pkg::KIND_HEIGHT, signed_value(), digp_pkg::ERR_NONE);
                    raise_error(digp_pkg::ERR_NO_HEIGHT_NL);
                end
                else
                    raise_error(digp_pkg::ERR_NO_HEIGHT);
            end
            digp_pkg::PH_RNUM:
            begin
                if (digit_seen)
                    push_result(digp_pkg::KIND_CELL, cell_value(), digp_pkg::ERR_NONE);
                push_result(digp_pkg::KIND_OK, '0, digp_pkg::ERR_NONE);
            end
            default:
                push_result(digp_pkg::KIND_OK, '0, digp_pkg::ERR_NONE);
        endcase
    endfunction

    function automatic void parse_item(logic [7:0] c, logic eot);
        step_results.delete();
        if (eot)
        begin
            if (!text_done)
                close_text();
            restart_text();
        end
        else if (!text_done)
            parse_char(c);
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        foreach (step_results[i])
            results_due.push_back(step_results[i]);
    endfunction

    // text builders
    function automatic void add_string(string s);
        foreach (s[i])
            text_buf.push_back(s[i]);
    endfunction

    function automatic void add_blanks(int lo, int hi);
        repeat ($urandom_range(hi, lo))
            text_buf.push_back($urandom_range(1) ? digp_pkg::CH_SP : digp_pkg::CH_TAB);
    endfunction

    function automatic void add_newlines();
        repeat ($urandom_range(3, 1))
            text_buf.push_back($urandom_range(1) ? digp_pkg::CH_LF : digp_pkg::CH_CR);
    endfunction

    function automatic void add_number();
        int digits;
        digits = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(3, 1);
        if ($urandom_range(3) == 0)
            text_buf.push_back(digp_pkg::CH_MINUS);
        repeat (digits)
            text_buf.push_back(digp_pkg::CH_0 + 8'($urandom_range(9)));
    endfunction

    function automatic void add_gap();
        if (is_blank(sep_char))
            add_blanks(1, 3);
        else
        begin
            if ($urandom_range(1))
                add_blanks(1, 2);
            text_buf.push_back(sep_char);
            if ($urandom_range(1))
                add_blanks(1, 2);
        end
    endfunction

    function automatic void build_grid();
        int rows;
        int cells;
        text_buf.delete();
        add_number();
        add_newlines();
        add_number();
        add_newlines();
        rows = $urandom_range(2, 1);
        for (int r = 0; r < rows; r++)
        begin
            cells = $urandom_range(3, 1);
            for (int k = 0; k < cells; k++)
            begin
                if (k > 0)
                    add_gap();
                add_number();
            end
            if ($urandom_range(3) == 0)
                add_blanks(1, 2);
            if (r < rows - 1 || $urandom_range(4) != 0)
                add_newlines();
            else if ($urandom_range(1))
                add_gap();
        end
    endfunction

    function automatic void damage_text();
        int idx;
        idx = $urandom_range(text_buf.size() - 1);
        case ($urandom_range(2))
            0: text_buf[idx] = 8'($urandom_range(255));
            1: text_buf.insert(idx, 8'($urandom_range(255)));
            default:
                while (text_buf.size() > idx)
                    void'(text_buf.pop_back());
        endcase
    endfunction

    function automatic void build_noise();
        text_buf.delete();
        repeat ($urandom_range(12, 1))
            text_buf.push_back(8'($urandom_range(255)));
    endfunction

    // handshakes
    task automatic send_item(logic [7:0] ch, logic eot);
        item       <= '{text_byte: ch, end_of_text: eot};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (eot || !text_done)
            active_items++;
        parse_item(ch, eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_item(text_buf[i], 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
        texts_sent++;
        chars_sent += text_buf.size();
    endtask

    task automatic pause_until_drained();
        item_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic check_separator_readback(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SEP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'b0, value})
        begin
            bad_results++;
            $display("%0t: separator readback expected %h got %h", $time, {24'b0, value},
                     prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_separator(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEP_ADDR;
        pwdata  <= {24'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sep_char = value;
        settings_used++;
        check_separator_readback(value);
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                bad_results++;
                $display("%0t: result with none due: kind %0d value %h err %0d line %0d last %0b",
                         $time, result.result_kind, result.number_value, result.error_code,
                         result.line_number, result.last_of_run);
            end
            else
            begin
                due_head = results_due.pop_front();
                if (result !== due_head)
                begin
                    bad_results++;
                    $display("%0t: expected kind %0d value %h err %0d line %0d last %0b",
                             $time, due_head.result_kind, due_head.number_value,
                             due_head.error_code, due_head.line_number, due_head.last_of_run);
                    $display("%0t: actual   kind %0d value %h err %0d line %0d last %0b",
                             $time, result.result_kind, result.number_value, result.error_code,
                             result.line_number, result.last_of_run);
                end
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            result_ready <= 1'b0;
            hold_left    = hold_request - 1;
            hold_request = 0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_register_reset();
        check_separator_readback(digp_pkg::SEP_RESET);
    endtask

    task automatic test_directed_texts();
        text_buf.delete();
        text_buf.push_back(8'hFF);
        send_text();
        text_buf.delete();
        add_string("9");
        text_buf.push_back(8'h00);
        send_text();
        text_buf.delete();
        add_string("4294967295\r-1\n7\t-0 \n");
        send_text();
    endtask

    task automatic test_random_texts();
        int send_pct[3] = '{27, 73, 0};
        int recv_pct[3] = '{73, 27, 0};
        logic [7:0] sep_choices[8] = '{digp_pkg::CH_SP, 8'h2c, digp_pkg::CH_TAB,
                                       digp_pkg::CH_LF, digp_pkg::CH_MINUS, 8'h35,
                                       8'h00, 8'hFF};
        int start;
        int pick;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            foreach (sep_choices[s])
            begin
                pause_until_drained();
                write_separator(sep_choices[s]);
                start = active_items;
                while (active_items - start < 8)
                begin
                    pick = $urandom_range(99);
                    if (pick < 85)
                        build_grid();
                    else
                        build_noise();
                    if (pick >= 65 && pick < 85)
                        damage_text();
                    send_text();
                end
            end
        end
    endtask

    task automatic test_result_backpressure();
        pause_until_drained();
        write_separator(digp_pkg::CH_SP);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        text_buf.delete();
        add_string("12\n3\n");
        repeat (16)
        begin
            add_number();
            add_gap();
        end
        add_number();
        add_newlines();
        hold_request = HOLD_CYCLES;
        send_text();
    endtask

    initial
    begin
        sep_char = digp_pkg::SEP_RESET;
        restart_text();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_texts();
        test_random_texts();
        test_result_backpressure();

        pause_until_drained();
        repeat (8)
            @(posedge clk);
        $display("Sent %0d texts (%0d characters) across %0d separator writes",
                 texts_sent, chars_sent, settings_used);
        $display("and three idle mixes; checked %0d results, %0d mismatches.",
                 results_seen, bad_results);
        if (bad_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/digp_pkg.sv
hw/rtl/digp_regs.sv
hw/rtl/digp_core.sv
hw/rtl/digp_queue.sv
hw/rtl/delimited_integer_grid_parser_unit.sv
dv/delimited_integer_grid_parser_unit_test.sv
